[rtl/grh_pkg.sv]
// Shared types and constants for the graph reachability / hop-sum block.
// Used by grh_adj_mem, grh_seq and graph_reach_and_hop_sum.
`timescale 1ns / 1ps
package grh_pkg;

    localparam int VERTEX_W       = 6;
    localparam int ROW_W          = 64;
    localparam int SUM_W          = 12;
    localparam int CNT_W          = 16;
    localparam int CMD_W          = 2;
    localparam int MAX_VERTEX_DEF = 63;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 96;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REACH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HOPS  = 2'd3;

    localparam logic [VERTEX_W-1:0] VERTEX_RESET = 6'd63;

    typedef struct packed {
        logic                rd_en;
        logic [VERTEX_W-1:0] rd_addr;
        logic                wr_en;
        logic [VERTEX_W-1:0] wr_addr;
        logic [ROW_W-1:0]    wr_data;
        logic                clr_all;
    } t_mem_req;

    typedef struct packed {
        logic [ROW_W-1:0] reach_mask;
        logic [SUM_W-1:0] distance_sum;
        logic [CNT_W-1:0] edge_count;
        logic             error;
    } t_result;

endpackage

[rtl/graph_reach_and_hop_sum.sv]
// A clear goes straight to the result; an edge add reads the row, then writes it back;
// a search sweeps rows 0..V (V = active vertex limit) once per level reached from the
// start vertex, plus a final sweep. One command in flight: the next is taken once the
// output register has taken the result; a full output register holds the sequencer.
// Reset (synchronous, active low): graph empty, edge counter 0, vertex_count 63.
// A row valid-bit flop per vertex clears the graph at once; no clearing pass.
`timescale 1ns / 1ps
module graph_reach_and_hop_sum #(
    parameter int P_MAX_VERTEX = grh_pkg::MAX_VERTEX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [grh_pkg::VERTEX_W-1:0]       i_cfg_wdata,   // vertex_count
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [grh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // vertex_a[5:0], vertex_b[11:6]
    input  logic [grh_pkg::CMD_W-1:0]          s_axis_tuser,  // command[1:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // reach_mask[63:0], distance_sum[75:64], edge_count[91:76]
    output logic [grh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [0:0]                         m_axis_tuser   // error[0]
);

    localparam int VW = grh_pkg::VERTEX_W;
    localparam logic [VW-1:0] MAX_V = VW'(P_MAX_VERTEX);

    logic [VW-1:0]     r_vertex_count;
    logic [VW-1:0]     limit;
    logic              seq_ready;
    logic              start;
    grh_pkg::t_mem_req mem_req;
    logic [grh_pkg::ROW_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_take;
    grh_pkg::t_result  seq_result;
    logic              r_out_vld;
    grh_pkg::t_result  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= grh_pkg::VERTEX_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    assign limit = (r_vertex_count < MAX_V) ? r_vertex_count : MAX_V;

    assign s_axis_tready = seq_ready;
    assign start         = s_axis_tvalid & seq_ready;

    grh_adj_mem #(
        .P_MAX_VERTEX (P_MAX_VERTEX)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    grh_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (s_axis_tuser),
        .i_vertex_a  (s_axis_tdata[VW-1:0]),
        .i_vertex_b  (s_axis_tdata[2*VW-1:VW]),
        .i_limit     (limit),
        .o_ready     (seq_ready),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_result    (seq_result)
    );

    // Output register: take a finished result whenever the slot is free or draining.
    assign res_take = res_valid & (~r_out_vld | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {
        (grh_pkg::OUT_TDATA_W - grh_pkg::ROW_W - grh_pkg::SUM_W - grh_pkg::CNT_W)'(0),
        r_out.edge_count, r_out.distance_sum, r_out.reach_mask
    };
    assign m_axis_tuser  = r_out.error;

endmodule

[rtl/grh_adj_mem.sv]
// Adjacency row memory: one write port, one registered read port, per-row valid bits.
// Depends on grh_pkg.
`timescale 1ns / 1ps
module grh_adj_mem #(
    parameter int P_MAX_VERTEX = grh_pkg::MAX_VERTEX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  grh_pkg::t_mem_req         i_req,
    output logic [grh_pkg::ROW_W-1:0] o_rdata
);

    localparam int DEPTH = P_MAX_VERTEX + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [grh_pkg::ROW_W-1:0] r_rows [DEPTH];
    logic [DEPTH-1:0]          r_row_vld;
    logic [grh_pkg::ROW_W-1:0] r_rdata;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_rows[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_rows[i_req.rd_addr[AW-1:0]];
        end
    end

    // A row never written since reset or clear reads as no edges.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.clr_all) begin
                r_row_vld <= '0;
            end else if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

[rtl/grh_seq.sv]
// Command sequencer: edge insert and level-by-level row sweep with a shared
// OR-accumulate / depth adder. Depends on grh_pkg; drives grh_adj_mem.
`timescale 1ns / 1ps
module grh_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [grh_pkg::CMD_W-1:0]    i_cmd,
    input  logic [grh_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [grh_pkg::VERTEX_W-1:0] i_vertex_b,
    input  logic [grh_pkg::VERTEX_W-1:0] i_limit,
    output logic                         o_ready,
    output grh_pkg::t_mem_req            o_mem_req,
    input  logic [grh_pkg::ROW_W-1:0]    i_mem_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output grh_pkg::t_result             o_result
);

    localparam int VW = grh_pkg::VERTEX_W;
    localparam int RW = grh_pkg::ROW_W;
    localparam int SW = grh_pkg::SUM_W;
    localparam int CW = grh_pkg::CNT_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD      = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_RESULT   = 3'd4;

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [2:0]                r_state, n_state;
    logic [grh_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [VW-1:0]             r_a, n_a;
    logic [VW-1:0]             r_b, n_b;
    logic [VW-1:0]             r_idx, n_idx;
    logic                      r_pv, n_pv;
    logic [VW-1:0]             r_pidx, n_pidx;
    logic [RW-1:0]             r_visit, n_visit;
    logic [RW-1:0]             r_front, n_front;
    logic [RW-1:0]             r_acc, n_acc;
    logic [VW-1:0]             r_depth, n_depth;
    logic [SW-1:0]             r_sum, n_sum;
    logic [CW-1:0]             r_ecnt, n_ecnt;
    grh_pkg::t_result          r_res, n_res;

    logic [RW-1:0] valid;
    logic [RW-1:0] start_bit;
    logic          proc;
    logic [RW-1:0] acc_nx;
    logic [SW-1:0] sum_nx;
    logic [RW-1:0] fresh;
    logic          a_bad;
    logic          b_bad;

    always_comb begin
        for (int i = 0; i < RW; i++) begin
            valid[i] = (VW'(i) <= i_limit);
        end
    end

    assign start_bit = RW'(1) << i_vertex_a;
    assign a_bad     = (i_vertex_a > i_limit);
    assign b_bad     = (i_vertex_b > i_limit);

    // Shared unit: fold one row into the neighbour set and add the level depth.
    assign proc   = r_pv & r_front[r_pidx];
    assign acc_nx = r_acc | (proc ? i_mem_rdata : '0);
    assign sum_nx = r_sum + (proc ? SW'(r_depth) : '0);
    assign fresh  = acc_nx & valid & ~r_visit;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_a       = r_a;
        n_b       = r_b;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pidx    = r_pidx;
        n_visit   = r_visit;
        n_front   = r_front;
        n_acc     = acc_nx;
        n_depth   = r_depth;
        n_sum     = sum_nx;
        n_ecnt    = r_ecnt;
        n_res     = r_res;
        o_mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_a   = i_vertex_a;
                    n_b   = i_vertex_b;
                    unique case (i_cmd)
                        grh_pkg::CMD_CLEAR: begin
                            o_mem_req.clr_all = 1'b1;
                            n_ecnt            = '0;
                            n_res             = '0;
                            n_state           = S_RESULT;
                        end
                        grh_pkg::CMD_ADD: begin
                            if (a_bad || b_bad) begin
                                n_res            = '0;
                                n_res.edge_count = r_ecnt;
                                n_res.error      = 1'b1;
                                n_state          = S_RESULT;
                            end else begin
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = i_vertex_a;
                                n_state           = S_ADD;
                            end
                        end
                        default: begin
                            if (a_bad) begin
                                n_res            = '0;
                                n_res.edge_count = r_ecnt;
                                n_res.error      = 1'b1;
                                n_state          = S_RESULT;
                            end else begin
                                // the hop search never enters vertex 0 from elsewhere
                                n_visit = start_bit
                                        | ((i_cmd == grh_pkg::CMD_HOPS) ? RW'(1) : '0);
                                n_front = start_bit;
                                n_acc   = '0;
                                n_sum   = '0;
                                n_depth = '0;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_ADD: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_a;
                o_mem_req.wr_data = i_mem_rdata | (RW'(1) << r_b);
                n_ecnt            = (r_ecnt == CNT_MAX) ? r_ecnt : r_ecnt + CW'(1);
                n_res             = '0;
                n_res.edge_count  = n_ecnt;
                n_state           = S_RESULT;
            end
            S_SCAN: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = r_idx;
                n_pv              = 1'b1;
                n_pidx            = r_idx;
                if (r_idx == i_limit) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + VW'(1);
                end
            end
            S_SCAN_END: begin
                if (fresh == '0) begin
                    n_res.reach_mask   = (r_cmd == grh_pkg::CMD_REACH) ? r_visit : '0;
                    n_res.distance_sum = (r_cmd == grh_pkg::CMD_HOPS) ? sum_nx : '0;
                    n_res.edge_count   = r_ecnt;
                    n_res.error        = 1'b0;
                    n_state            = S_RESULT;
                end else begin
                    n_visit = r_visit | fresh;
                    n_front = fresh;
                    n_acc   = '0;
                    n_depth = r_depth + VW'(1);
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ecnt  <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_ecnt  <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_a     <= n_a;
        r_b     <= n_b;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_visit <= n_visit;
        r_front <= n_front;
        r_acc   <= n_acc;
        r_depth <= n_depth;
        r_sum   <= n_sum;
        r_res   <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_result    = r_res;

`ifndef ASSERT_OFF
    a_scan_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= i_limit))
        else $error("sweep index beyond vertex limit");

    a_front_in_visit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SCAN_END) |-> ((r_front & ~r_visit) == '0))
        else $error("frontier holds an unvisited vertex");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.error)
            |-> (o_result.reach_mask == '0 && o_result.distance_sum == '0))
        else $error("error result carries search data");

    a_ecnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_mem_req.clr_all |=> (r_ecnt >= $past(r_ecnt)))
        else $error("edge counter dropped without a clear");
`endif

endmodule
